[sv/srqf_pkg.sv]
// Shared types, constants and helpers for the sequencing read quality filter.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package srqf_pkg;

  // Deepest trailing window the quality store supports by default.
  localparam int unsigned MAX_RIGHT_WINDOW_DEF = 256;

  localparam logic [7:0] UNKNOWN_BASE = 8'h4E;  // ASCII 'N'

  // Verdict reason codes.
  localparam logic [2:0] REASON_NONE         = 3'd0;
  localparam logic [2:0] REASON_LENGTH       = 3'd1;
  localparam logic [2:0] REASON_MEAN         = 3'd2;
  localparam logic [2:0] REASON_UNKNOWN      = 3'd3;
  localparam logic [2:0] REASON_OUT_OF_RANGE = 3'd4;
  localparam logic [2:0] REASON_LEFT         = 3'd5;
  localparam logic [2:0] REASON_RIGHT        = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [2:0] REG_LENGTH_BOUNDS      = 3'd0;
  localparam logic [2:0] REG_READ_QUAL_BOUNDS   = 3'd1;
  localparam logic [2:0] REG_LEFT_WINDOW_LEN    = 3'd2;
  localparam logic [2:0] REG_LEFT_QUAL_BOUNDS   = 3'd3;
  localparam logic [2:0] REG_RIGHT_WINDOW_LEN   = 3'd4;
  localparam logic [2:0] REG_RIGHT_QUAL_BOUNDS  = 3'd5;
  localparam logic [2:0] REG_MAX_OUT_OF_RANGE   = 3'd6;
  localparam logic [2:0] REG_MAX_UNKNOWN_BASES  = 3'd7;

  // Register reset values.
  localparam logic [31:0] LENGTH_BOUNDS_RST = 32'hFFFF_0000;
  localparam logic [15:0] QUAL_BOUNDS_RST   = 16'hFF00;
  localparam logic [15:0] MAX_COUNT_RST     = 16'hFFFF;

  // Rounded-mean divider widths: dividend 2*sum + d, divisor 2*d.
  localparam int unsigned DIV_NUM_W = 26;
  localparam int unsigned DIV_DEN_W = 17;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       wr_en;
    logic       clear;
    logic [7:0] wdata;
  } qmem_req_t;

  // True when v lies below the low byte or above the high byte of bounds.
  function automatic logic outside_bounds(input logic [DIV_NUM_W-1:0] v,
                                          input logic [15:0] bounds);
    return (v < DIV_NUM_W'(bounds[7:0])) || (v > DIV_NUM_W'(bounds[15:8]));
  endfunction

endpackage

`default_nettype wire

[sv/sequencing_read_quality_filter_top.sv]
// Top level of the sequencing read quality filter: per-read statistics,
// end-of-read sequencer and verdict register. Uses srqf_pkg, srqf_qmem, srqf_div.
`timescale 1ns / 1ps
`default_nettype none

// Bases of a read enter on the in_ stream one request at a time: in_tdata
// carries the base letter and the raw quality byte, in_tlast marks the last
// base. While a read streams, one base is taken every cycle; the trailing
// window sum is updated in the cycle after, from a ring store of recent
// qualities that is read and written at each base.
// After the last base the block stops taking bases and works out three
// rounded means (whole read, left window, right window) one after the other
// on a single serial divider, one quotient bit per cycle. The verdict is
// then loaded into the output register; the next read may start streaming
// in the cycle after.
// The verdict waits on the out_ stream until taken. If the receiver stalls,
// bases of the next read are still taken; only the following verdict waits
// for the output register to free up.
// Reset (synchronous, active low) restores the register defaults, clears
// all per-read counts and empties the output register. The quality store
// needs no clearing: a read only looks back at entries it wrote itself.
// Configuration writes take effect at the clock edge where cfg_wr_en is high.
module sequencing_read_quality_filter_top #(
  parameter int unsigned MAX_RIGHT_WINDOW = srqf_pkg::MAX_RIGHT_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Base requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] base_letter, [15:8] quality_byte
  input  wire logic        in_tlast,   // last_base
  // Verdict requests.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [0] passed, [3:1] fail_reason,
                                       // [11:4] mean_quality, [27:12] read_len
  // Configuration writes.
  input  wire logic        cfg_wr_en,
  input  wire logic [srqf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned WW   = $clog2(MAX_RIGHT_WINDOW + 1);
  localparam int unsigned CMPW = (WW > 9) ? WW : 9;
  localparam int unsigned NW   = srqf_pkg::DIV_NUM_W;
  localparam int unsigned DW   = srqf_pkg::DIV_DEN_W;

  // Sequencer states.
  localparam logic [2:0] ST_ACCEPT     = 3'd0;
  localparam logic [2:0] ST_MEAN_GO    = 3'd1;
  localparam logic [2:0] ST_MEAN_WAIT  = 3'd2;
  localparam logic [2:0] ST_LEFT_GO    = 3'd3;
  localparam logic [2:0] ST_LEFT_WAIT  = 3'd4;
  localparam logic [2:0] ST_RIGHT_GO   = 3'd5;
  localparam logic [2:0] ST_RIGHT_WAIT = 3'd6;
  localparam logic [2:0] ST_VERDICT    = 3'd7;

  // Configuration registers.
  logic [31:0] length_bounds_r;
  logic [15:0] read_qual_bounds_r;
  logic [15:0] left_window_len_r;
  logic [15:0] left_qual_bounds_r;
  logic [8:0]  right_window_len_r;
  logic [15:0] right_qual_bounds_r;
  logic [15:0] max_out_of_range_r;
  logic [15:0] max_unknown_bases_r;

  // Per-read statistics.
  logic [15:0] base_count_r, base_count_nxt;
  logic [23:0] quality_total_r, quality_total_nxt;
  logic [23:0] left_total_r, left_total_nxt;
  logic [15:0] right_total_r, right_total_nxt;
  logic [15:0] unknown_count_r, unknown_count_nxt;
  logic [15:0] oor_count_r, oor_count_nxt;

  // Second stage of the trailing-window update.
  logic        rb_valid_r, rb_valid_nxt;
  logic [7:0]  rb_q_r;
  logic        rb_sub_r;

  // Sequencer, captured division results and output register.
  logic [2:0]  state_r, state_nxt;
  logic [7:0]  mean_r;
  logic        left_out_r;
  logic        right_out_r;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_passed_r;
  logic [2:0]  out_reason_r;
  logic [7:0]  out_mean_r;
  logic [15:0] out_len_r;

  logic [7:0]  letter;
  logic [7:0]  qual;
  logic        in_fire;
  logic        counting;
  logic        cnt_fire;
  logic        out_free;
  logic        clear_read;
  logic [CMPW-1:0] win_raw;
  logic [WW-1:0]   w_eff;
  logic        win_on;
  logic [2:0]  reason;
  logic [7:0]  old_q;

  srqf_pkg::qmem_req_t qmem_req;
  srqf_pkg::div_req_t  div_req;
  srqf_pkg::div_rsp_t  div_rsp;

  assign letter   = in_tdata[7:0];
  assign qual     = in_tdata[15:8];
  assign in_tready = (state_r == ST_ACCEPT);
  assign in_fire  = in_tvalid & in_tready;
  // Bases past the saturated length change nothing but may still end the read.
  assign counting = (base_count_r != 16'hFFFF);
  assign cnt_fire = in_fire & counting;
  assign out_free = !out_tvalid_r || out_tready;
  assign clear_read = (state_r == ST_VERDICT) && out_free;

  // A right window above the store depth acts as the full depth.
  assign win_raw = CMPW'(right_window_len_r);
  assign w_eff   = (win_raw > CMPW'(MAX_RIGHT_WINDOW)) ? WW'(MAX_RIGHT_WINDOW)
                                                       : WW'(win_raw);
  assign win_on  = (w_eff != '0);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_bounds_r     <= srqf_pkg::LENGTH_BOUNDS_RST;
      read_qual_bounds_r  <= srqf_pkg::QUAL_BOUNDS_RST;
      left_window_len_r   <= '0;
      left_qual_bounds_r  <= srqf_pkg::QUAL_BOUNDS_RST;
      right_window_len_r  <= '0;
      right_qual_bounds_r <= srqf_pkg::QUAL_BOUNDS_RST;
      max_out_of_range_r  <= srqf_pkg::MAX_COUNT_RST;
      max_unknown_bases_r <= srqf_pkg::MAX_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        srqf_pkg::REG_LENGTH_BOUNDS:     length_bounds_r     <= cfg_data;
        srqf_pkg::REG_READ_QUAL_BOUNDS:  read_qual_bounds_r  <= cfg_data[15:0];
        srqf_pkg::REG_LEFT_WINDOW_LEN:   left_window_len_r   <= cfg_data[15:0];
        srqf_pkg::REG_LEFT_QUAL_BOUNDS:  left_qual_bounds_r  <= cfg_data[15:0];
        srqf_pkg::REG_RIGHT_WINDOW_LEN:  right_window_len_r  <= cfg_data[8:0];
        srqf_pkg::REG_RIGHT_QUAL_BOUNDS: right_qual_bounds_r <= cfg_data[15:0];
        srqf_pkg::REG_MAX_OUT_OF_RANGE:  max_out_of_range_r  <= cfg_data[15:0];
        srqf_pkg::REG_MAX_UNKNOWN_BASES: max_unknown_bases_r <= cfg_data[15:0];
      endcase
    end
  end

  // Quality ring store: written at each counted base, the entry leaving the
  // window is read in the same cycle and used by the second stage.
  assign qmem_req.wr_en = cnt_fire;
  assign qmem_req.clear = clear_read;
  assign qmem_req.wdata = qual;

  srqf_qmem #(
    .MAX_RIGHT_WINDOW (MAX_RIGHT_WINDOW),
    .WW               (WW)
  ) u_qmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (qmem_req),
    .win   (w_eff),
    .rdata (old_q)
  );

  // Statistics update.
  always_comb begin
    base_count_nxt    = base_count_r;
    quality_total_nxt = quality_total_r;
    left_total_nxt    = left_total_r;
    unknown_count_nxt = unknown_count_r;
    oor_count_nxt     = oor_count_r;
    right_total_nxt   = right_total_r;
    rb_valid_nxt      = cnt_fire & win_on;
    if (clear_read) begin
      base_count_nxt    = '0;
      quality_total_nxt = '0;
      left_total_nxt    = '0;
      unknown_count_nxt = '0;
      oor_count_nxt     = '0;
      right_total_nxt   = '0;
    end else begin
      if (cnt_fire) begin
        base_count_nxt    = base_count_r + 1'b1;
        quality_total_nxt = quality_total_r + 24'(qual);
        if (base_count_r < left_window_len_r) begin
          left_total_nxt = left_total_r + 24'(qual);
        end
        if (letter == srqf_pkg::UNKNOWN_BASE) begin
          unknown_count_nxt = unknown_count_r + 1'b1;
        end
        if (srqf_pkg::outside_bounds(NW'(qual), read_qual_bounds_r)) begin
          oor_count_nxt = oor_count_r + 1'b1;
        end
      end
      // The sliding sum runs modulo 2^16 and follows the base in the cycle after.
      if (rb_valid_r) begin
        right_total_nxt = right_total_r + 16'(rb_q_r) - (rb_sub_r ? 16'(old_q) : 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_count_r    <= '0;
      quality_total_r <= '0;
      left_total_r    <= '0;
      right_total_r   <= '0;
      unknown_count_r <= '0;
      oor_count_r     <= '0;
      rb_valid_r      <= 1'b0;
    end else begin
      base_count_r    <= base_count_nxt;
      quality_total_r <= quality_total_nxt;
      left_total_r    <= left_total_nxt;
      right_total_r   <= right_total_nxt;
      unknown_count_r <= unknown_count_nxt;
      oor_count_r     <= oor_count_nxt;
      rb_valid_r      <= rb_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_fire) begin
      rb_q_r   <= qual;
      rb_sub_r <= (base_count_r >= 16'(w_eff));
    end
  end

  // Rounded mean floor((2*sum + d) / (2*d)) on the shared divider. The
  // operands are chosen by the state that launches the division.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = NW'({quality_total_r, 1'b0}) + NW'(base_count_r);
    div_req.divisor  = DW'({base_count_r, 1'b0});
    unique case (state_r)
      ST_MEAN_GO: begin
        div_req.start = 1'b1;
      end
      ST_LEFT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = NW'({left_total_r, 1'b0}) + NW'(left_window_len_r);
        div_req.divisor  = DW'({left_window_len_r, 1'b0});
      end
      ST_RIGHT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = NW'({right_total_r, 1'b0}) + NW'(w_eff);
        div_req.divisor  = DW'({w_eff, 1'b0});
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  srqf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCEPT:     if (in_fire && in_tlast) state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:    state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (div_rsp.done) state_nxt = ST_LEFT_GO;
      ST_LEFT_GO:    state_nxt = ST_LEFT_WAIT;
      ST_LEFT_WAIT:  if (div_rsp.done) state_nxt = ST_RIGHT_GO;
      ST_RIGHT_GO:   state_nxt = ST_RIGHT_WAIT;
      ST_RIGHT_WAIT: if (div_rsp.done) state_nxt = ST_VERDICT;
      ST_VERDICT:    if (out_free) state_nxt = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The whole-read mean never exceeds the largest quality byte, so eight
  // bits hold it; the window means are reduced to a pass/fail flag.
  always_ff @(posedge clk) begin
    if (div_rsp.done) begin
      if (state_r == ST_MEAN_WAIT) begin
        mean_r <= div_rsp.quotient[7:0];
      end
      if (state_r == ST_LEFT_WAIT) begin
        left_out_r <= srqf_pkg::outside_bounds(div_rsp.quotient, left_qual_bounds_r);
      end
      if (state_r == ST_RIGHT_WAIT) begin
        right_out_r <= srqf_pkg::outside_bounds(div_rsp.quotient, right_qual_bounds_r);
      end
    end
  end

  // Checks in order; the first one that fails names the reason.
  always_comb begin
    priority if ((base_count_r < length_bounds_r[15:0]) ||
                 (base_count_r > length_bounds_r[31:16])) begin
      reason = srqf_pkg::REASON_LENGTH;
    end else if (srqf_pkg::outside_bounds(NW'(mean_r), read_qual_bounds_r)) begin
      reason = srqf_pkg::REASON_MEAN;
    end else if (unknown_count_r > max_unknown_bases_r) begin
      reason = srqf_pkg::REASON_UNKNOWN;
    end else if (oor_count_r > max_out_of_range_r) begin
      reason = srqf_pkg::REASON_OUT_OF_RANGE;
    end else if ((left_window_len_r != '0) && left_out_r) begin
      reason = srqf_pkg::REASON_LEFT;
    end else if (win_on && right_out_r) begin
      reason = srqf_pkg::REASON_RIGHT;
    end else begin
      reason = srqf_pkg::REASON_NONE;
    end
  end

  // Output register.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (clear_read) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_read) begin
      out_passed_r <= (reason == srqf_pkg::REASON_NONE);
      out_reason_r <= reason;
      out_mean_r   <= mean_r;
      out_len_r    <= base_count_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_len_r, out_mean_r, out_reason_r, out_passed_r};

endmodule

`default_nettype wire

[sv/srqf_qmem.sv]
// Ring store of the latest base qualities for the trailing-window sum.
// Uses srqf_pkg for its request struct.
`timescale 1ns / 1ps
`default_nettype none

module srqf_qmem #(
  parameter int unsigned MAX_RIGHT_WINDOW = srqf_pkg::MAX_RIGHT_WINDOW_DEF,
  parameter int unsigned WW = $clog2(MAX_RIGHT_WINDOW + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire srqf_pkg::qmem_req_t  req,
  input  wire logic [WW-1:0]        win,
  output logic [7:0]                rdata
);

  localparam int unsigned AW = (MAX_RIGHT_WINDOW > 1) ? $clog2(MAX_RIGHT_WINDOW) : 1;
  localparam int unsigned CW = ((AW > WW) ? AW : WW) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_RIGHT_WINDOW);
  localparam logic [AW-1:0] LAST_C  = AW'(MAX_RIGHT_WINDOW - 1);

  logic [7:0]    mem [MAX_RIGHT_WINDOW];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] wp_ext, win_ext, raddr_ext;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata_r;

  // Write pointer follows the base index modulo the depth.
  always_comb begin
    wp_nxt = wp_r;
    if (req.clear) begin
      wp_nxt = '0;
    end else if (req.wr_en) begin
      wp_nxt = (wp_r == LAST_C) ? '0 : wp_r + 1'b1;
    end
  end

  // The entry leaving the window sits win places behind the write pointer.
  assign wp_ext    = CW'(wp_r);
  assign win_ext   = CW'(win);
  assign raddr_ext = (wp_ext >= win_ext) ? wp_ext - win_ext : wp_ext + DEPTH_C - win_ext;
  assign raddr     = raddr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
    end
  end

  // Read-first: a full-depth window reads the old entry it overwrites.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wdata;
      rdata_r   <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/srqf_div.sv]
// Serial restoring divider, one quotient bit per cycle, for rounded means.
// Uses srqf_pkg for widths and request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module srqf_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire srqf_pkg::div_req_t  req,
  output srqf_pkg::div_rsp_t       rsp
);

  localparam int unsigned NW = srqf_pkg::DIV_NUM_W;
  localparam int unsigned DW = srqf_pkg::DIV_DEN_W;
  localparam int unsigned CNW = $clog2(NW);

  logic [NW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  den_r, den_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    trial;
  logic           fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = CNW'(NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

[sv/srqf_checker.sv]
// Port-level checker for the sequencing read quality filter, bound to the top.
// Uses srqf_pkg for reason codes.
`timescale 1ns / 1ps
`default_nettype none

module srqf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // A stalled verdict keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // After the last base of a read the block works on the verdict first.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("base taken right after end of read");

  // Passed is set exactly when no check failed.
  a_pass_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == srqf_pkg::REASON_NONE)))
    else $error("passed flag disagrees with reason");

  // Reason code stays within the defined set.
  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:1] <= srqf_pkg::REASON_RIGHT))
    else $error("undefined reason code");

  // Every read holds at least one base.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:12] != 16'd0))
    else $error("verdict for empty read");

endmodule

bind sequencing_read_quality_filter_top srqf_checker u_srqf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[test/srqf_verdict_checker.sv]
`timescale 1ns / 1ps
// Verdict checker for the sequencing read quality filter: watches the base, verdict and
// register-write ports, predicts every verdict and compares it field by field.
// Depends on srqf_pkg for reason codes, register indexes and register reset values.
module srqf_verdict_checker
  import srqf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [15:0]            in_tdata,    // [7:0] base_letter, [15:8] quality_byte
  input  logic                   in_tlast,    // last_base
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [31:0]            out_tdata,   // [0] passed, [3:1] fail_reason,
                                              // [11:4] mean_quality, [27:12] read_len
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     verdicts_checked,
  output int                     bases_taken
);

  localparam int unsigned RING_DEPTH = MAX_RIGHT_WINDOW_DEF;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  typedef struct packed {
    logic        passed;
    logic [2:0]  reason;
    logic [7:0]  mean_q;
    logic [15:0] length;
  } verdict_t;

  // Shadow copies of the filter registers, kept from the observed writes.
  logic [31:0] len_bounds;
  logic [15:0] read_qb;
  logic [15:0] left_len;
  logic [15:0] left_qb;
  logic [8:0]  right_len;
  logic [15:0] right_qb;
  logic [15:0] max_oor;
  logic [15:0] max_n;

  // Statistics of the read in flight.
  logic [15:0] base_cnt;
  logic [23:0] qual_sum;
  logic [23:0] lead_sum;
  logic [15:0] tail_sum;
  logic [15:0] n_cnt;
  logic [15:0] oor_cnt;
  logic [7:0]  tail_ring [RING_DEPTH];

  verdict_t expected_verdicts[$];
  int fail_tally;
  int checked_tally;
  int base_tally;

  function automatic logic [31:0] rounded_mean(input logic [31:0] total,
                                               input logic [31:0] divisor);
    logic [63:0] numer;
    logic [63:0] denom;
    numer = 64'(total) * 64'd2 + 64'(divisor);
    denom = 64'(divisor) * 64'd2;
    return 32'(numer / denom);
  endfunction

  function automatic logic off_bounds(input logic [31:0] v, input logic [15:0] bounds);
    return (v < 32'(bounds[7:0])) || (v > 32'(bounds[15:8]));
  endfunction

  task automatic clear_read();
    base_cnt = '0;
    qual_sum = '0;
    lead_sum = '0;
    tail_sum = '0;
    n_cnt    = '0;
    oor_cnt  = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] verdict %0d: %s mismatch, expected 0x%0h, got 0x%0h",
             $time, checked_tally, what, want, got);
    fail_tally++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      REG_LENGTH_BOUNDS:     len_bounds = value;
      REG_READ_QUAL_BOUNDS:  read_qb    = value[15:0];
      REG_LEFT_WINDOW_LEN:   left_len   = value[15:0];
      REG_LEFT_QUAL_BOUNDS:  left_qb    = value[15:0];
      REG_RIGHT_WINDOW_LEN:  right_len  = value[8:0];
      REG_RIGHT_QUAL_BOUNDS: right_qb   = value[15:0];
      REG_MAX_OUT_OF_RANGE:  max_oor    = value[15:0];
      REG_MAX_UNKNOWN_BASES: max_n      = value[15:0];
      default: ;
    endcase
  endtask

  // Folds one base into the read statistics and, on the last base, queues the verdict.
  task automatic take_base(input logic [7:0] letter, input logic [7:0] q, input logic last);
    int unsigned w;
    int unsigned n;
    int unsigned len;
    logic [31:0] mean;
    logic [2:0]  why;
    verdict_t    v;
    w = (right_len > RING_DEPTH) ? RING_DEPTH : right_len;
    // Past the saturation point a base leaves every statistic alone.
    if (base_cnt != 16'hFFFF) begin
      n = base_cnt;
      if (letter == UNKNOWN_BASE) n_cnt++;
      if (off_bounds(32'(q), read_qb)) oor_cnt++;
      qual_sum += 24'(q);
      if (n < left_len) lead_sum += 24'(q);
      if (w != 0) begin
        // A read still shorter than the window keeps the sum of all its bases.
        tail_sum = tail_sum + 16'(q);
        if (n >= w) tail_sum = tail_sum - 16'(tail_ring[RING_AW'((n - w) % RING_DEPTH)]);
      end
      tail_ring[RING_AW'(n % RING_DEPTH)] = q;
      base_cnt = 16'(n + 1);
    end
    if (last) begin
      len  = base_cnt;
      mean = rounded_mean(32'(len), 32'(len)) == 0 ? 0 : rounded_mean(32'(qual_sum), len);
      if (len < len_bounds[15:0] || len > len_bounds[31:16])
        why = REASON_LENGTH;
      else if (off_bounds(mean, read_qb))
        why = REASON_MEAN;
      else if (n_cnt > max_n)
        why = REASON_UNKNOWN;
      else if (oor_cnt > max_oor)
        why = REASON_OUT_OF_RANGE;
      else if (left_len != 0 &&
               off_bounds(rounded_mean(32'(lead_sum), 32'(left_len)), left_qb))
        why = REASON_LEFT;
      else if (w != 0 && off_bounds(rounded_mean(32'(tail_sum), w), right_qb))
        why = REASON_RIGHT;
      else
        why = REASON_NONE;
      v.passed = (why == REASON_NONE);
      v.reason = why;
      v.mean_q = mean[7:0];
      v.length = 16'(len);
      expected_verdicts.push_back(v);
      clear_read();
    end
    base_tally++;
  endtask

  task automatic check_verdict(input logic [31:0] word);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("unexpected verdict", 32'd0, word);
      return;
    end
    want = expected_verdicts.pop_front();
    if (word[0] !== want.passed)
      report_mismatch("passed", 32'(want.passed), 32'(word[0]));
    if (word[3:1] !== want.reason)
      report_mismatch("fail_reason", 32'(want.reason), 32'(word[3:1]));
    if (word[11:4] !== want.mean_q)
      report_mismatch("mean_quality", 32'(want.mean_q), 32'(word[11:4]));
    if (word[27:12] !== want.length)
      report_mismatch("read_len", 32'(want.length), 32'(word[27:12]));
    checked_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      len_bounds = LENGTH_BOUNDS_RST;
      read_qb    = QUAL_BOUNDS_RST;
      left_len   = '0;
      left_qb    = QUAL_BOUNDS_RST;
      right_len  = '0;
      right_qb   = QUAL_BOUNDS_RST;
      max_oor    = MAX_COUNT_RST;
      max_n      = MAX_COUNT_RST;
      clear_read();
      expected_verdicts.delete();
    end else begin
      if (cfg_wr_en) write_reg(cfg_index, cfg_data);
      // Verdicts are retired before the new base is folded in.
      if (out_tvalid && out_tready) check_verdict(out_tdata);
      if (in_tvalid && in_tready) take_base(in_tdata[7:0], in_tdata[15:8], in_tlast);
    end
    mismatches       <= fail_tally;
    pending          <= expected_verdicts.size();
    verdicts_checked <= checked_tally;
    bases_taken      <= base_tally;
  end

endmodule

[test/tb_sequencing_read_quality_filter_top.sv]
`timescale 1ns / 1ps
// Testbench top for the sequencing read quality filter: clock, reset, base and register
// stimulus, receiver stalls and the final verdict. Depends on srqf_pkg, the block and
// srqf_verdict_checker, which does all prediction and comparison.
module tb_sequencing_read_quality_filter_top
  import srqf_pkg::*;
;

  // Verdicts come out after the block's end-of-read work; settling waits beyond that.
  localparam int SETTLE_CYCLES   = 150;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_BASES    = 300;
  localparam int RANDOM_READS    = 20;
  localparam logic [31:0] NUCLEOTIDES = "ACGT";

  typedef enum logic [1:0] {RX_STEADY, RX_PATTERN, RX_LONG_STALLS} rx_mode_t;

  // One full set of filter register values.
  typedef struct {
    logic [31:0] len_bounds;
    logic [15:0] read_qb;
    logic [15:0] left_len;
    logic [15:0] left_qb;
    logic [8:0]  right_len;
    logic [15:0] right_qb;
    logic [15:0] max_oor;
    logic [15:0] max_n;
  } reg_set_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [31:0]            out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data  = '0;

  int mismatches;
  int pending;
  int verdicts_checked;
  int bases_taken;

  // Sender burst shaping; a gap limit of zero streams bases back to back.
  int gap_max    = 0;
  int burst_max  = 1;
  int burst_left = 0;
  int bases_sent = 0;
  int reads_sent = 0;
  int settings_used = 0;
  reg_set_t active;

  // Receiver behavior, chosen per phase.
  rx_mode_t    rx_mode = RX_STEADY;
  logic [15:0] rx_mask = 16'hFFFF;
  logic [3:0]  rx_tick = '0;
  int          rx_hold = 0;

  sequencing_read_quality_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  srqf_verdict_checker verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending),
    .verdicts_checked (verdicts_checked),
    .bases_taken      (bases_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver either always takes verdicts, follows a repeating 16-bit mask, or
  // alternates long stalls with short ready windows. Long stalls can outlast the block's
  // end-of-read work, so the next read's verdict may wait on the output register.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    case (rx_mode)
      RX_STEADY: out_tready <= 1'b1;
      RX_PATTERN: out_tready <= rx_mask[rx_tick];
      default: begin
        if (rx_hold == 0) begin
          out_tready <= ~out_tready;
          rx_hold <= out_tready ? int'($urandom_range(1, 150)) : int'($urandom_range(0, 4));
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // Hard stop in case a verdict never shows up.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d verdicts outstanding.", CYCLE_LIMIT, pending);
    $display("** sequencing_read_quality_filter_top: FAILED **");
    $finish;
  end

  // Offers one base and holds it until the block takes it. Between bursts the sender
  // drops valid for a random number of cycles.
  task automatic send_base(input logic [7:0] letter, input logic [7:0] qual, input logic last);
    if (gap_max != 0 && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
    if (burst_left != 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {qual, letter};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bases_sent++;
  endtask

  // A run of identical bases, optionally closing the read.
  task automatic send_run(input logic [7:0] letter, input logic [7:0] qual, input int count,
                          input logic closes);
    for (int i = 0; i < count; i++) send_base(letter, qual, closes && i == count - 1);
    if (closes) reads_sent++;
  endtask

  // Mostly real nucleotides, a fair share of unknown bases and some arbitrary bytes.
  function automatic logic [7:0] pick_letter();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return UNKNOWN_BASE;
    if (roll < 6) return 8'($urandom);
    return NUCLEOTIDES[8 * $urandom_range(0, 3) +: 8];
  endfunction

  // Qualities scatter around a center, with an occasional extreme byte thrown in.
  function automatic logic [7:0] pick_quality(input int center, input int spread);
    int v;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // A read of random length whose qualities mostly sit inside the current read bounds,
  // so that the later checks in the chain get reached. A few reads are longer than the
  // deepest trailing window to wrap the quality store.
  task automatic send_random_read();
    int unsigned len;
    int unsigned roll;
    int          center;
    int          spread;
    logic [7:0]  lo;
    logic [7:0]  hi;
    roll = $urandom_range(0, 99);
    if (roll < 85) len = $urandom_range(1, 10);
    else if (roll < 95) len = $urandom_range(11, 40);
    else len = $urandom_range(250, 300);
    lo = active.read_qb[7:0];
    hi = active.read_qb[15:8];
    if (lo <= hi && $urandom_range(0, 3) != 0) center = $urandom_range(lo, hi);
    else center = $urandom_range(0, 255);
    spread = $urandom_range(0, 40);
    for (int i = 0; i < len; i++)
      send_base(pick_letter(), pick_quality(center, spread), i == len - 1);
    reads_sent++;
  endtask

  function automatic logic [15:0] pick_bounds();
    logic [7:0] lo;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    lo = 8'($urandom_range(0, 60));
    return {8'($urandom_range(lo + 20, 255)), lo};
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t    s;
    int unsigned min_len;
    int unsigned roll;
    min_len = $urandom_range(0, 4);
    roll = $urandom_range(0, 9);
    if (roll == 0) s.len_bounds = $urandom;
    else if (roll < 3) s.len_bounds = {16'hFFFF, 16'(min_len)};
    else s.len_bounds = {16'($urandom_range(min_len + 4, 320)), 16'(min_len)};
    s.read_qb = pick_bounds();
    roll = $urandom_range(0, 9);
    if (roll < 3) s.left_len = '0;
    else if (roll < 9) s.left_len = 16'($urandom_range(1, 12));
    else s.left_len = 16'($urandom);
    s.left_qb = pick_bounds();
    roll = $urandom_range(0, 19);
    if (roll < 5) s.right_len = '0;
    else if (roll < 16) s.right_len = 9'($urandom_range(1, 12));
    else if (roll == 16) s.right_len = 9'(MAX_RIGHT_WINDOW_DEF);
    else if (roll < 19) s.right_len = 9'($urandom_range(MAX_RIGHT_WINDOW_DEF + 1, 511));
    else s.right_len = 9'($urandom);
    s.right_qb = pick_bounds();
    s.max_oor = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
    s.max_n   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
    return s;
  endfunction

  // One register write per cycle; the enable comes down once after the last one.
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input reg_set_t s);
    put_reg(REG_LENGTH_BOUNDS,     s.len_bounds);
    put_reg(REG_READ_QUAL_BOUNDS,  32'(s.read_qb));
    put_reg(REG_LEFT_WINDOW_LEN,   32'(s.left_len));
    put_reg(REG_LEFT_QUAL_BOUNDS,  32'(s.left_qb));
    put_reg(REG_RIGHT_WINDOW_LEN,  32'(s.right_len));
    put_reg(REG_RIGHT_QUAL_BOUNDS, 32'(s.right_qb));
    put_reg(REG_MAX_OUT_OF_RANGE,  32'(s.max_oor));
    put_reg(REG_MAX_UNKNOWN_BASES, 32'(s.max_n));
    cfg_wr_en <= 1'b0;
    active = s;
    settings_used++;
  endtask

  // Picks how bursty the sender is and how the receiver stalls for the next phase.
  task automatic pick_traffic();
    case ($urandom_range(0, 2))
      0: gap_max = 0;
      1: gap_max = 3;
      default: gap_max = 12;
    endcase
    burst_max  = $urandom_range(1, 40);
    burst_left = 0;
    rx_mode <= rx_mode_t'($urandom_range(0, 2));
    rx_mask <= 16'($urandom) | 16'h0001;
  endtask

  // Drops valid, waits for every queued verdict and lets the block settle so that
  // registers can be written with nothing in flight.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    reg_set_t s;
    int       base_mark;
    int       read_mark;

    active.len_bounds = LENGTH_BOUNDS_RST;
    active.read_qb    = QUAL_BOUNDS_RST;
    active.left_len   = '0;
    active.left_qb    = QUAL_BOUNDS_RST;
    active.right_len  = '0;
    active.right_qb   = QUAL_BOUNDS_RST;
    active.max_oor    = MAX_COUNT_RST;
    active.max_n      = MAX_COUNT_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A few reads under the reset values, where every read should pass.
    pick_traffic();
    repeat (4) send_random_read();
    finish_phase();

    // Directed reads, each aimed at one step of the check chain. Length 2..8, read
    // qualities 33..73, three leading and four trailing bases checked against 40..80,
    // at most two out-of-range bases and one unknown base.
    s.len_bounds = {16'd8, 16'd2};
    s.read_qb    = {8'd73, 8'd33};
    s.left_len   = 16'd3;
    s.left_qb    = {8'd80, 8'd40};
    s.right_len  = 9'd4;
    s.right_qb   = {8'd80, 8'd40};
    s.max_oor    = 16'd2;
    s.max_n      = 16'd1;
    apply_settings(s);
    pick_traffic();
    // Too short, with the lowest quality and the highest letter byte.
    send_run(8'hFF, 8'h00, 1, 1'b1);
    // Mean at the top quality byte, above the read bounds.
    send_run(UNKNOWN_BASE, 8'hFF, 2, 1'b1);
    // Two unknown bases against a limit of one.
    send_run(UNKNOWN_BASE, 8'd50, 2, 1'b0);
    send_run("A", 8'd50, 1, 1'b1);
    // Mean in bounds but three bases out of range.
    send_run("C", 8'd10, 1, 1'b0);
    send_run("C", 8'd90, 1, 1'b0);
    send_run("C", 8'd10, 1, 1'b0);
    send_run("C", 8'd50, 1, 1'b1);
    // Weak start of the read trips the leading window.
    send_run("G", 8'd34, 3, 1'b0);
    send_run("G", 8'd70, 1, 1'b1);
    // Weak end of the read trips the trailing window.
    send_run("T", 8'd70, 2, 1'b0);
    send_run("T", 8'd34, 4, 1'b1);
    // A clean read.
    send_run("T", 8'd50, 4, 1'b1);
    // Read shorter than the trailing window: its whole sum is divided by the window.
    send_run("A", 8'd50, 3, 1'b1);
    // Read shorter than the leading window as well.
    send_run("C", 8'd60, 2, 1'b1);
    finish_phase();

    // Register extremes: a length window that nothing fits, closed quality bounds,
    // exactly the deepest trailing window and no tolerance for odd bases.
    s.len_bounds = 32'h0000_0000;
    s.read_qb    = 16'h0000;
    s.left_len   = 16'd1;
    s.left_qb    = 16'h0000;
    s.right_len  = 9'(MAX_RIGHT_WINDOW_DEF);
    s.right_qb   = 16'hFFFF;
    s.max_oor    = 16'h0000;
    s.max_n      = 16'h0000;
    apply_settings(s);
    pick_traffic();
    repeat (4) send_random_read();
    finish_phase();

    // Random phases: fresh register values and traffic shape each time, several reads
    // per phase, until enough bases and verdicts have gone through.
    base_mark = bases_sent;
    read_mark = reads_sent;
    while (bases_sent - base_mark < RANDOM_BASES || reads_sent - read_mark < RANDOM_READS) begin
      apply_settings(random_settings());
      pick_traffic();
      repeat ($urandom_range(3, 10)) send_random_read();
      finish_phase();
    end

    $display("Covered %0d bases in %0d reads under %0d register settings, %0d verdicts checked.",
             bases_taken, reads_sent, settings_used, verdicts_checked);
    $display("Traffic mixed bursty senders with steady, patterned and long-stall receivers; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** sequencing_read_quality_filter_top: PASSED **");
    end else begin
      $display("** sequencing_read_quality_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

[sequencing_read_quality_filter_top.f]
sv/srqf_pkg.sv
sv/srqf_qmem.sv
sv/srqf_div.sv
sv/sequencing_read_quality_filter_top.sv
sv/srqf_checker.sv
test/srqf_verdict_checker.sv
test/tb_sequencing_read_quality_filter_top.sv
